>>> rtl/mrpd_pkg.sv
// shared types and constants of the ramped pwm dimmer
`timescale 1ns / 1ps
`default_nettype none
package mrpd_pkg;

	// request opcodes
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RAMP = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_PWM_EN    = 2'd0;
	localparam logic [1:0] REG_CONT_LOAD = 2'd1;
	localparam logic [1:0] REG_FORCE_SEL = 2'd2;
	localparam logic [1:0] REG_FORCE_VAL = 2'd3;

	localparam int unsigned MASK_W  = 16;
	localparam int unsigned LEVEL_W = 8;
	localparam logic [LEVEL_W-1:0] FULL_ON = 8'hFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TICK,
		ST_RAMP,
		ST_DONE
	} seq_state_t;

	// strobes from the sequencer to the datapath
	typedef struct packed {
		logic accept;
		logic busy;
		logic tick_walk;
		logic ramp_walk;
		logic load_out;
	} seq_ctl_t;

	// result of the shared channel unit
	typedef struct packed {
		logic [LEVEL_W-1:0] level_nxt;
		logic               at_set;
		logic               sel;
	} chan_res_t;

endpackage
`default_nettype wire

>>> rtl/mrpd_chan_unit.sv
// shared per-channel compare and add unit for ramp and pwm walks
`timescale 1ns / 1ps
`default_nettype none
module mrpd_chan_unit #(
	parameter int unsigned DIMM_LOW = 0
) (
	input  wire logic [7:0]          cur,
	input  wire logic [7:0]          tgt,
	input  wire logic [7:0]          dlt,
	input  wire logic [7:0]          phase,
	input  wire logic                wrap,
	output mrpd_pkg::chan_res_t      res
);
	import mrpd_pkg::*;

	logic [8:0] up_lim;
	logic       dn_ok;

	assign up_lim = {1'b0, tgt} + {1'b0, dlt};
	assign dn_ok  = (tgt > dlt) && (cur < (tgt - dlt));

	always_comb begin
		res.at_set = (cur == tgt);
		if (cur == tgt) begin
			res.level_nxt = cur;
		end else if ({1'b0, cur} > up_lim) begin
			res.level_nxt = cur - dlt;
		end else if (dn_ok) begin
			res.level_nxt = cur + dlt;
		end else begin
			// within one step: snap
			res.level_nxt = tgt;
		end
		// wrap: switch on above low bound, else switch off once phase reaches level
		if (wrap) begin
			res.sel = (cur > LEVEL_W'(DIMM_LOW));
		end else begin
			res.sel = (phase >= cur);
		end
	end

endmodule
`default_nettype wire

>>> rtl/mrpd_seq.sv
// sequencer that walks the channels for tick and ramp requests
`timescale 1ns / 1ps
`default_nettype none
module mrpd_seq #(
	parameter int unsigned CHANNELS = 16,
	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          opcode,
	input  wire logic                out_free,
	output mrpd_pkg::seq_ctl_t       ctl,
	output logic [CW-1:0]            cnt
);
	import mrpd_pkg::*;

	seq_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          last;

	assign last = (cnt_q == CW'(CHANNELS - 1));
	assign cnt  = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		ctl.accept    = 1'b0;
		ctl.busy      = 1'b1;
		ctl.tick_walk = 1'b0;
		ctl.ramp_walk = 1'b0;
		ctl.load_out  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctl.busy   = 1'b0;
				ctl.accept = in_valid;
				if (in_valid) begin
					case (opcode)
						OP_TICK: state_d = ST_TICK;
						OP_RAMP: state_d = ST_RAMP;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_TICK, ST_RAMP: begin
				ctl.tick_walk = (state_q == ST_TICK);
				ctl.ramp_walk = (state_q == ST_RAMP);
				if (last) begin
					cnt_d   = '0;
					state_d = ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after accepting a request");

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("channel counter not cleared while idle");

	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after result load");

endmodule
`default_nettype wire

>>> rtl/multichannel_ramped_pwm_dimmer_unit.sv
// top level of the multichannel ramped pwm dimmer
`timescale 1ns / 1ps
`default_nettype none
// Multichannel ramped PWM dimmer. Three request kinds arrive on the input
// channel: pwm tick (opcode 0), ramp step (opcode 1) and set channel
// (opcode 2); opcode 3 changes nothing. Every request yields exactly one
// result carrying pin levels, setpoint mask and pwm phase as they stand after
// the request. Set channel and the unused opcode go from accept straight to
// the result load; tick and ramp first walk the channels, one channel per
// cycle, over one shared channel unit and then load the result. The load
// waits while the output register is full and stalled.
// The block takes one request at a time; in_stall is high after accept
// until the result moves into the output register, which then holds it
// until the consumer takes it, so the next request may already be accepted.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and should only change while the block is idle.
module multichannel_ramped_pwm_dimmer_unit #(
	parameter int unsigned CHANNELS  = 16,
	parameter int unsigned DIMM_LOW  = 0,
	parameter int unsigned DIMM_HIGH = 60
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [3:0]  channel,
	input  wire logic [7:0]  target_level,
	input  wire logic [7:0]  step_size,
	input  wire logic        trigger_load,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [15:0]      pin_levels,
	output logic [15:0]      setpoint_mask,
	output logic [7:0]       pwm_phase
);
	import mrpd_pkg::*;

	localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// configuration registers
	logic              pwm_en_q;
	logic [MASK_W-1:0] cont_q;
	logic [MASK_W-1:0] fsel_q;
	logic [MASK_W-1:0] fval_q;

	// per-channel state
	logic [LEVEL_W-1:0] level_q  [CHANNELS];
	logic [LEVEL_W-1:0] tgt_q    [CHANNELS];
	logic [LEVEL_W-1:0] step_q   [CHANNELS];
	logic [LEVEL_W-1:0] stg_tgt_q[CHANNELS];
	logic [LEVEL_W-1:0] stg_step_q[CHANNELS];
	logic [MASK_W-1:0]  pending_q;
	logic [MASK_W-1:0]  setpt_q;
	logic [MASK_W-1:0]  pin_q;
	logic [7:0]         phase_q;
	logic               wrap_q;

	// result register
	logic              out_valid_q;
	logic [MASK_W-1:0] pin_out_q;
	logic [MASK_W-1:0] setpt_out_q;
	logic [7:0]        phase_out_q;

	seq_ctl_t      ctl;
	logic [CW-1:0] cnt;
	logic          out_free;
	chan_res_t     res;

	// walk-side view of the current channel
	logic               ld;
	logic [LEVEL_W-1:0] eff_tgt;
	logic [LEVEL_W-1:0] eff_step;
	logic               ch_ok;
	logic [7:0]         phase_inc;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = ctl.busy;
	assign out_valid = out_valid_q;
	assign pin_levels    = pin_out_q;
	assign setpoint_mask = setpt_out_q;
	assign pwm_phase     = phase_out_q;

	// pending or continuous channels take the staged values this ramp step
	assign ld       = pending_q[cnt] | cont_q[cnt];
	assign eff_tgt  = ld ? stg_tgt_q[cnt]  : tgt_q[cnt];
	assign eff_step = ld ? stg_step_q[cnt] : step_q[cnt];
	assign ch_ok    = ({1'b0, channel} < 5'(CHANNELS));
	assign phase_inc = phase_q + 8'd1;

	mrpd_seq #(
		.CHANNELS(CHANNELS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.opcode  (opcode),
		.out_free(out_free),
		.ctl     (ctl),
		.cnt     (cnt)
	);

	mrpd_chan_unit #(
		.DIMM_LOW(DIMM_LOW)
	) u_chan (
		.cur  (level_q[cnt]),
		.tgt  (eff_tgt),
		.dlt  (eff_step),
		.phase(phase_q),
		.wrap (wrap_q),
		.res  (res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_en_q <= 1'b0;
			cont_q   <= '0;
			fsel_q   <= '0;
			fval_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PWM_EN:    pwm_en_q <= cfg_data[0];
				REG_CONT_LOAD: cont_q   <= cfg_data;
				REG_FORCE_SEL: fsel_q   <= cfg_data;
				REG_FORCE_VAL: fval_q   <= cfg_data;
				default:       pwm_en_q <= pwm_en_q;
			endcase
		end
	end

	// channel state, phase and pin bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				level_q[i]    <= '0;
				tgt_q[i]      <= '0;
				step_q[i]     <= '0;
				stg_tgt_q[i]  <= '0;
				stg_step_q[i] <= '0;
			end
			pending_q <= '0;
			setpt_q   <= '0;
			pin_q     <= '0;
			phase_q   <= 8'(DIMM_LOW);
			wrap_q    <= 1'b0;
		end else begin
			if (ctl.accept) begin
				case (opcode)
					OP_TICK: begin
						// advance phase, wrap at the period top
						if (phase_inc == 8'(DIMM_HIGH)) begin
							phase_q <= 8'(DIMM_LOW);
							wrap_q  <= 1'b1;
						end else begin
							phase_q <= phase_inc;
							wrap_q  <= 1'b0;
						end
					end
					OP_SET: begin
						if (ch_ok) begin
							stg_tgt_q[channel[CW-1:0]]  <= target_level;
							stg_step_q[channel[CW-1:0]] <= step_size;
							if (trigger_load) begin
								pending_q[channel[CW-1:0]] <= 1'b1;
							end
						end
					end
					default: begin
						wrap_q <= wrap_q;
					end
				endcase
			end
			if (ctl.tick_walk && pwm_en_q && res.sel) begin
				// on at wrap, off once phase reaches level
				pin_q[cnt] <= wrap_q;
			end
			if (ctl.ramp_walk) begin
				if (ld) begin
					pending_q[cnt] <= 1'b0;
					tgt_q[cnt]     <= stg_tgt_q[cnt];
					step_q[cnt]    <= stg_step_q[cnt];
				end
				if (fsel_q[cnt]) begin
					// forced channel: plain on or off, setpoint bit untouched
					level_q[cnt] <= fval_q[cnt] ? FULL_ON : '0;
				end else begin
					level_q[cnt] <= res.level_nxt;
					setpt_q[cnt] <= res.at_set;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pin_out_q   <= pin_q;
			setpt_out_q <= setpt_q;
			phase_out_q <= phase_q;
		end
	end

	a_load_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> out_valid)
		else $error("result load did not raise out_valid");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pin_levels)
			&& $stable(setpoint_mask) && $stable(pwm_phase)))
		else $error("stalled result changed or dropped");

	a_busy_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.tick_walk || ctl.ramp_walk || ctl.load_out) |-> in_stall)
		else $error("input not stalled while a request is in flight");

endmodule
`default_nettype wire

>>> bench/tb_multichannel_ramped_pwm_dimmer_unit.sv
// self-checking testbench of the multichannel ramped pwm dimmer
`timescale 1ns / 1ps
module tb_multichannel_ramped_pwm_dimmer_unit;
	import mrpd_pkg::*;

	localparam int unsigned CHANNELS  = 16;
	localparam int unsigned DIMM_LOW  = 0;
	localparam int unsigned DIMM_HIGH = 60;
	// opcode that the block passes over without any change
	localparam logic [1:0] OP_NOP = 2'd3;
	// cycles the receiver holds off in one go to back the block up
	localparam int unsigned LONG_HOLD = 80;

	typedef struct {
		logic [1:0]         op;
		logic [3:0]         ch;
		logic [LEVEL_W-1:0] tl;
		logic [LEVEL_W-1:0] ss;
		logic               trig;
	} dim_req_t;

	typedef struct {
		logic [MASK_W-1:0]  pins;
		logic [MASK_W-1:0]  setp;
		logic [LEVEL_W-1:0] phase;
	} dim_readout_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = '0;
	logic [3:0]         channel = '0;
	logic [7:0]         target_level = '0;
	logic [7:0]         step_size = '0;
	logic               trigger_load = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        pin_levels;
	logic [15:0]        setpoint_mask;
	logic [7:0]         pwm_phase;

	multichannel_ramped_pwm_dimmer_unit #(
		.CHANNELS (CHANNELS),
		.DIMM_LOW (DIMM_LOW),
		.DIMM_HIGH(DIMM_HIGH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.channel      (channel),
		.target_level (target_level),
		.step_size    (step_size),
		.trigger_load (trigger_load),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pin_levels   (pin_levels),
		.setpoint_mask(setpoint_mask),
		.pwm_phase    (pwm_phase)
	);

	always #1 clk = ~clk;

	// requests waiting to be offered and readouts still owed by the block
	dim_req_t     request_backlog[$];
	dim_readout_t expected_readouts[$];
	dim_req_t     offered;
	int           fail_count = 0;
	int unsigned  send_gap_pct = 0;
	int unsigned  recv_stall_pct = 0;
	logic         long_hold_go = 1'b0;
	logic         long_hold_done;
	int unsigned  hold_count;

	// shadow of the dimmer state
	logic [LEVEL_W-1:0] lvl      [CHANNELS];
	logic [LEVEL_W-1:0] act_tgt  [CHANNELS];
	logic [LEVEL_W-1:0] act_step [CHANNELS];
	logic [LEVEL_W-1:0] stg_tgt  [CHANNELS];
	logic [LEVEL_W-1:0] stg_step [CHANNELS];
	logic [MASK_W-1:0]  pend_mask;
	logic [MASK_W-1:0]  setp_bits;
	logic [LEVEL_W-1:0] phase_cnt;
	logic [MASK_W-1:0]  pin_bits;
	// shadow of the configuration registers
	logic               pwm_on;
	logic [MASK_W-1:0]  cont_load;
	logic [MASK_W-1:0]  force_sel;
	logic [MASK_W-1:0]  force_val;

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			lvl[c] = '0;
			act_tgt[c] = '0;
			act_step[c] = '0;
			stg_tgt[c] = '0;
			stg_step[c] = '0;
		end
		pend_mask = '0;
		setp_bits = '0;
		phase_cnt = LEVEL_W'(DIMM_LOW);
		pin_bits = '0;
		pwm_on = 1'b0;
		cont_load = '0;
		force_sel = '0;
		force_val = '0;
	end

	// applies one accepted request to the shadow state and queues the readout
	task automatic advance_dimmer(input dim_req_t r);
		dim_readout_t      ro;
		logic [MASK_W-1:0] sel;
		int unsigned       cur, goal, dlt;
		int                c;
		sel = '0;
		case (r.op)
			OP_TICK: begin
				phase_cnt = phase_cnt + 1'b1;
				if (phase_cnt == LEVEL_W'(DIMM_HIGH)) begin
					// top of the period: wrap and switch lit channels on
					phase_cnt = LEVEL_W'(DIMM_LOW);
					for (c = 0; c < CHANNELS; c++)
						sel[c] = lvl[c] > LEVEL_W'(DIMM_LOW);
					if (pwm_on)
						pin_bits = pin_bits | sel;
				end else begin
					for (c = 0; c < CHANNELS; c++)
						sel[c] = phase_cnt >= lvl[c];
					if (pwm_on)
						pin_bits = pin_bits & ~sel;
				end
			end
			OP_RAMP: begin
				for (c = 0; c < CHANNELS; c++) begin
					if (pend_mask[c] || cont_load[c]) begin
						pend_mask[c] = 1'b0;
						act_step[c] = stg_step[c];
						act_tgt[c] = stg_tgt[c];
					end
					if (force_sel[c]) begin
						// forced channels keep their setpoint bit
						lvl[c] = force_val[c] ? FULL_ON : '0;
					end else begin
						cur = lvl[c];
						goal = act_tgt[c];
						dlt = act_step[c];
						if (cur == goal) begin
							setp_bits[c] = 1'b1;
						end else begin
							setp_bits[c] = 1'b0;
							if (cur > goal + dlt)
								lvl[c] = LEVEL_W'(cur - dlt);
							else if (goal > dlt && cur < goal - dlt)
								lvl[c] = LEVEL_W'(cur + dlt);
							else
								lvl[c] = LEVEL_W'(goal);
						end
					end
				end
			end
			OP_SET: begin
				stg_tgt[r.ch] = r.tl;
				stg_step[r.ch] = r.ss;
				if (r.trig)
					pend_mask[r.ch] = 1'b1;
			end
			default: ;
		endcase
		ro.pins = pin_bits;
		ro.setp = setp_bits;
		ro.phase = phase_cnt;
		expected_readouts.push_back(ro);
	endtask

	// driver: offers backlog requests, holds the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				advance_dimmer(offered);
			if (!in_valid || !in_stall) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					offered = request_backlog.pop_front();
					in_valid <= 1'b1;
					opcode <= offered.op;
					channel <= offered.ch;
					target_level <= offered.tl;
					step_size <= offered.ss;
					trigger_load <= offered.trig;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_count <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
			out_stall <= 1'b1;
		end else if (long_hold_go && !long_hold_done) begin
			long_hold_done <= 1'b1;
			hold_count <= LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	function automatic void check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// monitor: every taken readout against the oldest expectation
	always @(posedge clk) begin
		dim_readout_t ro;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readouts.size() == 0) begin
				$display("%0t: unexpected readout, expected none got %h %h %h", $time,
					pin_levels, setpoint_mask, pwm_phase);
				fail_count++;
			end else begin
				ro = expected_readouts.pop_front();
				check_field("pin_levels", ro.pins, pin_levels);
				check_field("setpoint_mask", ro.setp, setpoint_mask);
				check_field("pwm_phase", 16'(ro.phase), 16'(pwm_phase));
			end
		end
	end

	function automatic void push_req(input logic [1:0] op, input logic [3:0] ch,
			input logic [7:0] tl, input logic [7:0] ss, input logic trig);
		dim_req_t r;
		r.op = op;
		r.ch = ch;
		r.tl = tl;
		r.ss = ss;
		r.trig = trig;
		request_backlog.push_back(r);
	endfunction

	// mostly ticks, ramps and triggered sets; half of the targets and most steps
	// are kept small so that many levels land inside the pwm period
	function automatic void push_random_reqs(input int n);
		int unsigned pick;
		logic [1:0]  op;
		logic [7:0]  tl, ss;
		repeat (n) begin
			pick = $urandom_range(99);
			op = pick < 50 ? OP_TICK : pick < 72 ? OP_RAMP : pick < 97 ? OP_SET : OP_NOP;
			tl = $urandom_range(1) ? 8'($urandom_range(70)) : 8'($urandom);
			pick = $urandom_range(9);
			ss = pick == 0 ? 8'd0 : pick == 1 ? 8'hFF : 8'($urandom_range(24, 1));
			push_req(op, 4'($urandom_range(15)), tl, ss, $urandom_range(99) < 80);
		end
	endfunction

	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_backlog.size() != 0 || in_valid || expected_readouts.size() != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PWM_EN:    pwm_on = val[0];
			REG_CONT_LOAD: cont_load = val;
			REG_FORCE_SEL: force_sel = val;
			REG_FORCE_VAL: force_val = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// block is idle here: nothing queued, nothing owed
	task automatic configure(input logic en, input logic [15:0] cont, input logic [15:0] fsel,
			input logic [15:0] fval);
		wait_drained();
		// upper bits of the enable word are don't-care
		write_reg(REG_PWM_EN, {15'($urandom), en});
		write_reg(REG_CONT_LOAD, cont);
		write_reg(REG_FORCE_SEL, fsel);
		write_reg(REG_FORCE_VAL, fval);
	endtask

	initial begin
		send_gap_pct = 13;
		recv_stall_pct = 45;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: pwm off, every channel sits at its zero target
		push_req(OP_TICK, 4'd0, 8'd0, 8'd0, 1'b0);
		push_req(OP_RAMP, 4'd0, 8'd0, 8'd0, 1'b0);
		push_req(OP_TICK, 4'd0, 8'd0, 8'd0, 1'b0);

		// ch1 continuous, ch14 forced on, ch15 forced off
		configure(1'b1, 16'h0002, 16'hC000, 16'h4000);
		push_req(OP_SET, 4'd0, 8'hFF, 8'hFF, 1'b1);
		push_req(OP_SET, 4'd1, 8'd0, 8'd0, 1'b0);
		// zero step leaves the level off target
		push_req(OP_SET, 4'd2, 8'd100, 8'd0, 1'b1);
		// ramps up by 20 and snaps onto 50
		push_req(OP_SET, 4'd3, 8'd50, 8'd20, 1'b1);
		push_req(OP_SET, 4'd14, 8'd77, 8'd3, 1'b1);
		push_req(OP_SET, 4'd15, 8'd200, 8'd9, 1'b1);
		push_req(OP_NOP, 4'd15, 8'hFF, 8'hFF, 1'b1);
		repeat (4) push_req(OP_RAMP, 4'd0, 8'd0, 8'd0, 1'b0);
		// full scale down in one step
		push_req(OP_SET, 4'd0, 8'd0, 8'hFF, 1'b1);
		repeat (2) push_req(OP_RAMP, 4'd0, 8'd0, 8'd0, 1'b0);
		repeat (8) push_req(OP_TICK, 4'd0, 8'd0, 8'd0, 1'b0);
		// staged without trigger: not loaded on the next ramp step
		push_req(OP_SET, 4'd3, 8'd10, 8'd5, 1'b0);
		push_req(OP_RAMP, 4'd0, 8'd0, 8'd0, 1'b0);

		configure(1'b1, 16'h0000, 16'h0000, 16'h0000);
		push_random_reqs(150);

		send_gap_pct = 45;
		recv_stall_pct = 13;
		// pwm off: pins hold while the phase runs on
		configure(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
		push_random_reqs(75);
		configure(1'b1, 16'hFFFF, 16'($urandom), 16'hFFFF);
		push_random_reqs(75);

		send_gap_pct = 0;
		recv_stall_pct = 0;
		configure(1'b1, 16'($urandom), 16'h0000, 16'h0000);
		long_hold_go = 1'b1;
		push_random_reqs(120);
		configure(1'b1, 16'h0000, 16'hFFFF, 16'h0000);
		push_random_reqs(30);

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_readouts.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
rtl/mrpd_pkg.sv
rtl/mrpd_chan_unit.sv
rtl/mrpd_seq.sv
rtl/multichannel_ramped_pwm_dimmer_unit.sv
bench/tb_multichannel_ramped_pwm_dimmer_unit.sv
